// ===== sv/vnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer package
// Shared widths, latencies and constants of the vector normalizer pipeline.
// ----------------------------------------------------------------------------
package vnorm_pkg;
    localparam int COMP_W      = 32;
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int QUOT_W      = 32;
    localparam int LEN_W       = 33;
    localparam int DOT_W       = 66;
    localparam int SHIFT_W     = 5;
    localparam int FRONT_LAT   = 4;
    localparam int SQRT_LAT    = ROOT_W;
    localparam int DIV_LAT     = QUOT_W;
    localparam logic [QUOT_W-1:0] UNIT_ONE = QUOT_W'(1) << 30;

    typedef struct packed {
        logic [2:0]        neg_comp;
        logic              neg_len;
        logic              zero;
    } side_t;
endpackage

// ===== sv/vnorm_delay.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer delay line
// Enabled shift line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module vnorm_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] tap_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                tap_reg[i] <= '0;
            end
        end else if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];
endmodule

// ===== sv/vnorm_front.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer front end
// Magnitudes, squares, dot product and the common normalizing shift.
// ----------------------------------------------------------------------------
module vnorm_front (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [vnorm_pkg::COMP_W-1:0] vec_in [3],
    input  logic signed [vnorm_pkg::COMP_W-1:0] ref_in [3],
    input  logic                              mode_in,
    output logic [vnorm_pkg::SUM_W-1:0]       sum_out,
    output logic [vnorm_pkg::SUM_W-1:0]       ssum_out,
    output logic [vnorm_pkg::COMP_W-1:0]      smag_out [3],
    output vnorm_pkg::side_t                  side_out
);
    import vnorm_pkg::*;

    logic [COMP_W-1:0]        mag_reg [3];
    logic [2:0]               sgn_reg, sgn2_reg, sgn3_reg;
    logic signed [COMP_W-1:0] vec_reg [3];
    logic signed [COMP_W-1:0] ref_reg [3];
    logic                     mode_reg, mode2_reg;
    logic [SUM_W-1:0]         sq_reg [3];
    logic signed [SUM_W-1:0]  dp_reg [3];
    logic [COMP_W-1:0]        mag2_reg [3];
    logic [COMP_W-1:0]        mag3_reg [3];
    logic [COMP_W-1:0]        max_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic [SHIFT_W-1:0]       k_reg;
    logic                     neg_reg;
    logic [COMP_W-1:0]        max_next;
    logic [SHIFT_W-1:0]       k_next;

    always_comb begin
        max_next = mag_reg[0];
        if (mag_reg[1] > max_next) begin
            max_next = mag_reg[1];
        end
        if (mag_reg[2] > max_next) begin
            max_next = mag_reg[2];
        end
    end

    always_comb begin
        k_next = SHIFT_W'(31);
        for (int p = 0; p < 30; p++) begin
            if (max_reg[p]) begin
                k_next = SHIFT_W'(30 - p);
            end
        end
        if (max_reg[31] || max_reg[30]) begin
            k_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i]  <= vec_in[i][COMP_W-1] ? COMP_W'(-vec_in[i]) : COMP_W'(vec_in[i]);
                sgn_reg[i]  <= vec_in[i][COMP_W-1];
                vec_reg[i]  <= vec_in[i];
                ref_reg[i]  <= ref_in[i];
                sq_reg[i]   <= SUM_W'(mag_reg[i]) * SUM_W'(mag_reg[i]);
                dp_reg[i]   <= SUM_W'(vec_reg[i]) * SUM_W'(ref_reg[i]);
                mag2_reg[i] <= mag_reg[i];
                mag3_reg[i] <= mag2_reg[i];
                smag_out[i] <= COMP_W'(mag3_reg[i] << k_reg);
            end
            mode_reg  <= mode_in;
            sgn2_reg  <= sgn_reg;
            max_reg   <= max_next;
            mode2_reg <= mode_reg;
            sgn3_reg  <= sgn2_reg;
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            dot_reg   <= DOT_W'(dp_reg[0]) + DOT_W'(dp_reg[1]) + DOT_W'(dp_reg[2]);
            k_reg     <= k_next;
            neg_reg   <= mode2_reg;
            sum_out   <= sum_reg;
            ssum_out  <= sum_reg << {k_reg, 1'b0};
            side_out.neg_comp <= sgn3_reg;
            side_out.neg_len  <= neg_reg && dot_reg[DOT_W-1];
            side_out.zero     <= (sum_reg == '0);
        end
    end
endmodule

// ===== sv/vnorm_sqrt.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vnorm_sqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [vnorm_pkg::SUM_W-1:0]   op_in,
    output logic [vnorm_pkg::ROOT_W-1:0]  root_out
);
    import vnorm_pkg::*;

    localparam int TW = SUM_W + 2;

    logic [SUM_W-1:0]  rem_reg [ROOT_W+1];
    logic [ROOT_W-1:0] res_reg [ROOT_W+1];

    assign rem_reg[0] = op_in;
    assign res_reg[0] = '0;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic [TW-1:0] trial;
        always_comb begin
            trial = (TW'(res_reg[j]) << (B + 1)) + (TW'(1) << (2 * B));
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (TW'(rem_reg[j]) >= trial) begin
                    rem_reg[j+1] <= SUM_W'(TW'(rem_reg[j]) - trial);
                    res_reg[j+1] <= res_reg[j] | (ROOT_W'(1) << B);
                end else begin
                    rem_reg[j+1] <= rem_reg[j];
                    res_reg[j+1] <= res_reg[j];
                end
            end
        end
    end

    assign root_out = res_reg[ROOT_W];
endmodule

// ===== sv/vnorm_div.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vnorm_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [vnorm_pkg::COMP_W-1:0]  smag_in,
    input  logic [vnorm_pkg::ROOT_W-1:0]  root_in,
    output logic [vnorm_pkg::QUOT_W-1:0]  quot_out
);
    import vnorm_pkg::*;

    localparam int NUM_W = COMP_W + 30;

    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] rem_reg [QUOT_W+1];
    logic [QUOT_W-1:0] low_reg [QUOT_W+1];
    logic [QUOT_W-1:0] q_reg   [QUOT_W+1];
    logic [ROOT_W-1:0] den_reg [QUOT_W+1];

    assign num        = {smag_in, 30'b0} + NUM_W'(root_in >> 1);
    assign rem_reg[0] = ROOT_W'(num[NUM_W-1:QUOT_W]);
    assign low_reg[0] = num[QUOT_W-1:0];
    assign q_reg[0]   = '0;
    assign den_reg[0] = root_in;

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        logic [ROOT_W:0] part;
        assign part = {rem_reg[j], low_reg[j][QUOT_W-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                low_reg[j+1] <= low_reg[j] << 1;
                den_reg[j+1] <= den_reg[j];
                if (part >= {1'b0, den_reg[j]}) begin
                    rem_reg[j+1] <= ROOT_W'(part - {1'b0, den_reg[j]});
                    q_reg[j+1]   <= {q_reg[j][QUOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[j+1] <= ROOT_W'(part);
                    q_reg[j+1]   <= {q_reg[j][QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quot_out = q_reg[QUOT_W];
endmodule

// ===== sv/frustum_vector_normalizer.sv =====
// ----------------------------------------------------------------------------
// Frustum vector normalizer
// Unit direction (Q1.30) and signed Euclidean length (Q16.16) of a vector.
// ----------------------------------------------------------------------------
// The block takes one request every cycle while the output is not stalled;
// each result passes through four front-end stages, a 32-stage square root,
// one numerator stage, a 32-stage divider and the output register. The whole
// pipeline advances together and holds while a finished result waits.
module frustum_vector_normalizer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x, vec_y, vec_z, ref_x, ref_y, ref_z, 32 bits each.
    input  logic [191:0] s_tdata,
    // signed_mode.
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // unit_x, unit_y, unit_z (32 bits each), length (33 bits), 7 zero bits.
    output logic [135:0] m_tdata,
    // zero_vector.
    output logic [0:0]   m_tuser
);
    import vnorm_pkg::*;

    localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + 1 + DIV_LAT;
    localparam int SIDE_W    = $bits(side_t);

    logic                     en;
    logic                     valid_end;
    logic signed [COMP_W-1:0] vec_in [3];
    logic signed [COMP_W-1:0] ref_in [3];
    logic [SUM_W-1:0]         sum, ssum;
    logic [COMP_W-1:0]        smag [3];
    logic [COMP_W-1:0]        smag_d [3];
    logic [COMP_W-1:0]        smag_reg [3];
    side_t                    side, side_d;
    logic [ROOT_W-1:0]        len_root, r_root, r_reg, len_d;
    logic [QUOT_W-1:0]        quot [3];
    logic [QUOT_W-1:0]        sat [3];
    logic [LEN_W-1:0]         len_next;
    logic [135:0]             tdata_next;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign vec_in[i] = s_tdata[COMP_W*i +: COMP_W];
        assign ref_in[i] = s_tdata[COMP_W*(i+3) +: COMP_W];
    end

    vnorm_delay #(.W(1), .N(TOTAL_LAT)) u_valid (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(s_tvalid), .dout(valid_end)
    );

    vnorm_front u_front (
        .aclk(aclk), .en(en), .vec_in(vec_in), .ref_in(ref_in), .mode_in(s_tuser[0]),
        .sum_out(sum), .ssum_out(ssum), .smag_out(smag), .side_out(side)
    );

    vnorm_sqrt u_len_sqrt (.aclk(aclk), .en(en), .op_in(sum), .root_out(len_root));
    vnorm_sqrt u_r_sqrt   (.aclk(aclk), .en(en), .op_in(ssum), .root_out(r_root));

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vnorm_delay #(.W(COMP_W), .N(SQRT_LAT)) u_smag (
            .aclk(aclk), .aresetn(aresetn), .en(en), .din(smag[i]), .dout(smag_d[i])
        );
        vnorm_div u_div (
            .aclk(aclk), .en(en), .smag_in(smag_reg[i]), .root_in(r_reg), .quot_out(quot[i])
        );
        assign sat[i] = (quot[i] > UNIT_ONE) ? UNIT_ONE : quot[i];
    end

    vnorm_delay #(.W(SIDE_W), .N(SQRT_LAT + 1 + DIV_LAT)) u_side (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(side), .dout(side_d)
    );
    vnorm_delay #(.W(ROOT_W), .N(1 + DIV_LAT)) u_len (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(len_root), .dout(len_d)
    );

    always_comb begin
        len_next = side_d.neg_len ? LEN_W'(-{1'b0, len_d}) : {1'b0, len_d};
    end

    always_comb begin
        tdata_next = '0;
        if (!side_d.zero) begin
            for (int i = 0; i < 3; i++) begin
                tdata_next[COMP_W*i +: COMP_W] =
                    side_d.neg_comp[i] ? COMP_W'(-sat[i]) : sat[i];
            end
            tdata_next[3*COMP_W +: LEN_W] = len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= r_root;
            smag_reg <= smag_d;
            m_tdata  <= tdata_next;
            m_tuser  <= side_d.zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= valid_end;
        end
    end
endmodule

// ===== dv/frustum_vector_normalizer_tb.sv =====
// ----------------------------------------------------------------------------
// Frustum vector normalizer testbench
// Drives vectors and reference directions through the stream input, predicts
// unit direction, length, sign and zero flag for each request, and compares
// every returned result in order under random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frustum_vector_normalizer_tb;
    import vnorm_pkg::*;

    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic [32:0] len;
        logic        zero;
    } norm_result_t;

    function automatic logic [63:0] int_sqrt(input logic [63:0] op);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > op) b = b >> 2;
        while (b != 0) begin
            if (op >= res + b) begin
                op = op - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic norm_result_t normalize(input logic [191:0] d, input logic mode);
        norm_result_t o;
        logic signed [31:0] v [3];
        logic signed [31:0] rf [3];
        logic [63:0] m [3];
        logic [63:0] s [3];
        logic [63:0] q;
        logic [63:0] sum, len, maxm, r;
        logic signed [67:0] dot;
        int k;
        for (int i = 0; i < 3; i++) begin
            v[i] = d[32*i +: 32];
            rf[i] = d[96 + 32*i +: 32];
            m[i] = v[i] < 0 ? 64'(-64'(signed'(v[i]))) : 64'(v[i]);
        end
        o = '0;
        sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        if (sum == 0) begin
            o.zero = 1'b1;
            return o;
        end
        len = int_sqrt(sum);
        maxm = m[0];
        if (m[1] > maxm) maxm = m[1];
        if (m[2] > maxm) maxm = m[2];
        k = 0;
        while ((maxm << k) < 64'(UNIT_ONE) && k < 31) k++;
        for (int i = 0; i < 3; i++) s[i] = m[i] << k;
        r = int_sqrt(s[0]*s[0] + s[1]*s[1] + s[2]*s[2]);
        for (int i = 0; i < 3; i++) begin
            q = (s[i] * 64'(UNIT_ONE) + (r >> 1)) / r;
            if (q > 64'(UNIT_ONE)) q = 64'(UNIT_ONE);
            if (v[i] < 0) q = -q;
            if (i == 0) o.ux = q[31:0];
            else if (i == 1) o.uy = q[31:0];
            else o.uz = q[31:0];
        end
        dot = 0;
        for (int i = 0; i < 3; i++) dot = dot + 68'(rf[i]) * 68'(v[i]);
        o.len = (mode && dot < 0) ? 33'(-len) : len[32:0];
        return o;
    endfunction

    int errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("error: %s got %h expected %h", what, got, want);
        errors++;
    endtask

    class normal_scoreboard;
        norm_result_t pending[$];

        function void note_request(input logic [191:0] d, input logic mode);
            pending.push_back(normalize(d, mode));
        endfunction

        task check_result(input logic [135:0] d, input logic zflag);
            norm_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", d[63:0], 0);
                return;
            end
            w = pending.pop_front();
            if (d[31:0] !== w.ux) report_mismatch("unit_x", d[31:0], w.ux);
            if (d[63:32] !== w.uy) report_mismatch("unit_y", d[63:32], w.uy);
            if (d[95:64] !== w.uz) report_mismatch("unit_z", d[95:64], w.uz);
            if (d[128:96] !== w.len) report_mismatch("length", d[128:96], w.len);
            if (zflag !== w.zero) report_mismatch("zero_vector", zflag, w.zero);
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;
    logic [0:0]   m_tuser;

    frustum_vector_normalizer dut (.*);

    normal_scoreboard sb = new();
    bit sending_done = 0;
    int idle_cycles = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] rand_comp(input int sz);
        logic [31:0] c;
        case ($urandom_range(0, 9))
            0: c = 0;
            1: c = 32'h8000_0000;
            2: c = 32'h7fff_ffff;
            3, 4: c = $urandom;
            default: c = 32'(signed'($urandom_range(0, 2*sz) - sz));
        endcase
        return c;
    endfunction

    task automatic send(input logic [191:0] d, input logic mode);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(d, mode);
    endtask

    task automatic send_random(input int n);
        logic [191:0] d;
        int burst, sz;
        while (n > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0) begin
                sz = $urandom_range(0, 3) == 0 ? 1 << $urandom_range(0, 30) : 1 << 17;
                for (int i = 0; i < 6; i++) d[32*i +: 32] = rand_comp(sz);
                send(d, $urandom_range(0, 1));
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    initial begin
        logic [31:0] mx, mn, one;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        one = 32'h0001_0000;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send({96'h0, 96'h0}, 1'b0);
        send({one, one, one, 32'h0, 32'h0, 32'h0}, 1'b1);
        send({96'h0, 32'h0, 32'h0, one}, 1'b1);
        send({32'h0, 32'h0, one, 32'h0, 32'h0, -one}, 1'b1);
        send({32'h0, 32'h0, one, 32'h0, 32'h0, -one}, 1'b0);
        send({32'h0, one, 32'h0, 32'h0, 32'h0, one}, 1'b1);
        send({mn, mn, mn, mn, mn, mn}, 1'b1);
        send({mx, mx, mx, mx, mx, mx}, 1'b1);
        send({mn, mn, mn, mx, mx, mx}, 1'b1);
        send({mx, mx, mx, mn, mn, mn}, 1'b1);
        send({mx, mx, mx, mn, mn, mn}, 1'b0);
        send({96'h0, 32'h0, 32'h0, 32'h1}, 1'b0);
        send({96'h0, 32'h0, 32'h0, 32'hffff_ffff}, 1'b0);
        send({96'h0, 32'h0, mn, 32'h0}, 1'b0);
        send({96'h0, 32'h1, 32'h1, 32'h1}, 1'b0);
        send({96'h0, 32'h3, 32'h4, 32'h0}, 1'b0);
        send({96'h0, mx, 32'h1, 32'hffff_ffff}, 1'b1);
        send({96'hffff_ffff_ffff_ffff_ffff_ffff, 96'h0}, 1'b1);
        send({32'h0, one, 32'h0, one, 32'h0, 32'h0}, 1'b1);
        send_random(1530);
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    // Receiver stall pattern, with one long hold-off early on.
    initial begin
        int phase;
        m_tready <= 1'b0;
        @(posedge aresetn);
        repeat (30) @(posedge aclk);
        repeat (300) @(posedge aclk);
        phase = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if ((phase / 200) % 3 == 1) m_tready <= 1'b1;
            else if (phase % 7 == 3) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end

    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (sending_done && sb.pending.size() == 0) begin
                repeat (150) @(posedge aclk);
                if (errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
                else $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end
endmodule

// ===== frustum_vector_normalizer.f =====
sv/vnorm_pkg.sv
sv/vnorm_delay.sv
sv/vnorm_front.sv
sv/vnorm_sqrt.sv
sv/vnorm_div.sv
sv/frustum_vector_normalizer.sv
dv/frustum_vector_normalizer_tb.sv
